// File: rtl/tef_pkg.sv
// shared types, codes and constants for the tab expansion filter
`timescale 1ns / 1ps

package tef_pkg;

    // character codes
    localparam logic [7:0] TAB_CODE     = 8'd9;
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;

    // stop table layout
    localparam int STOP_SLOTS = 8;
    localparam int STOP_W     = 6;
    localparam int MAX_STOPS  = 8;

    // widths
    localparam int COLUMN_W   = 16;
    localparam int RUN_W      = 6;
    localparam int COUNT_W    = 4;
    localparam int CFG_DATA_W = STOP_SLOTS * STOP_W;
    localparam int CFG_INDEX_W = 1;

    localparam logic [RUN_W-1:0] RUN_LIMIT = '1;

    // default tab interval
    localparam int DEFAULT_INTERVAL_DEF = 8;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_STOP_COUNT = 1'b0,
        REG_STOP_TABLE = 1'b1
    } cfg_reg_t;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_char;
        logic load_tab;
        logic load_space;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_tab;
        logic run_one;
        logic rem_one;
    } stat_t;

endpackage

// File: rtl/tef_ctrl.sv
// controller: handshake control and run sequencing for the tab expansion filter
`timescale 1ns / 1ps

module tef_ctrl
    import tef_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   accept;

    // output register can take a new item
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // outputs
    always_comb
    begin
        cmd.load_char  = accept && !stat.is_tab;
        cmd.load_tab   = accept && stat.is_tab;
        cmd.load_space = (state_reg == ST_RUN) && out_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && stat.is_tab && !stat.run_one)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (out_free && stat.rem_one)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        if (cmd.load_char || cmd.load_tab || cmd.load_space)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/tef_datapath.sv
// datapath: config registers, column tracking, stop search and output register
`timescale 1ns / 1ps

module tef_datapath
    import tef_pkg::*;
#(
    parameter int DEFAULT_INTERVAL = DEFAULT_INTERVAL_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [7:0]             s_tdata,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast,
    input  cmd_t                   cmd,
    output stat_t                  stat
);

    localparam int PHASE_W = (DEFAULT_INTERVAL > 1) ? $clog2(DEFAULT_INTERVAL) : 1;
    localparam int IVL_W   = $clog2(DEFAULT_INTERVAL + 1);
    localparam int DEF_W   = (IVL_W > RUN_W) ? IVL_W : RUN_W;
    localparam logic [PHASE_W-1:0] PHASE_TOP = PHASE_W'(DEFAULT_INTERVAL - 1);
    localparam logic [DEF_W-1:0]   IVL_VAL   = DEF_W'(DEFAULT_INTERVAL);

    logic [COUNT_W-1:0]    stop_count_reg;
    logic [CFG_DATA_W-1:0] stop_table_reg;
    logic [COLUMN_W-1:0]   column_reg;
    logic [COLUMN_W-1:0]   column_next;
    logic [PHASE_W-1:0]    phase_reg;
    logic [PHASE_W-1:0]    phase_next;
    logic [RUN_W-1:0]      remain_reg;
    logic [7:0]            data_reg;
    logic                  last_reg;
    logic [COUNT_W-1:0]    count_eff;
    logic [RUN_W-1:0]      run;
    logic [RUN_W-1:0]      stop_run;
    logic                  stop_hit;
    logic [DEF_W-1:0]      def_run;

    // config registers, writes to unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg <= '0;
            stop_table_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_STOP_COUNT: stop_count_reg <= cfg_data[COUNT_W-1:0];
                REG_STOP_TABLE: stop_table_reg <= cfg_data;
                default:        stop_count_reg <= stop_count_reg;
            endcase
        end
    end

    // clamp stop count
    assign count_eff = (stop_count_reg > COUNT_W'(MAX_STOPS)) ?
                       COUNT_W'(MAX_STOPS) : stop_count_reg;

    // first user stop beyond the column, slots checked in parallel
    always_comb
    begin
        logic [STOP_W-1:0] stop;
        stop_hit = 1'b0;
        stop_run = '0;
        for (int k = STOP_SLOTS - 1; k >= 0; k--)
        begin
            stop = stop_table_reg[k*STOP_W +: STOP_W];
            if ((COUNT_W'(k) < count_eff) &&
                (COLUMN_W'(stop) > column_reg))
            begin
                stop_hit = 1'b1;
                stop_run = stop - column_reg[STOP_W-1:0];
            end
        end
    end

    // default run to the next interval multiple, capped
    assign def_run = IVL_VAL - DEF_W'(phase_reg);

    always_comb
    begin
        if (stop_hit)
        begin
            run = stop_run;
        end
        else if (def_run > DEF_W'(RUN_LIMIT))
        begin
            run = RUN_LIMIT;
        end
        else
        begin
            run = def_run[RUN_W-1:0];
        end
    end

    // status
    assign stat.is_tab  = (s_tdata == TAB_CODE);
    assign stat.run_one = (run == RUN_W'(1));
    assign stat.rem_one = (remain_reg == RUN_W'(1));

    // column and phase advance once per emitted item, an emitted newline clears both
    always_comb
    begin
        column_next = column_reg;
        phase_next  = phase_reg;
        if (cmd.load_char && (s_tdata == NEWLINE_CODE))
        begin
            column_next = '0;
            phase_next  = '0;
        end
        else if (cmd.load_char || cmd.load_tab || cmd.load_space)
        begin
            column_next = column_reg + COLUMN_W'(1);
            if ((column_reg == '1) || (phase_reg == PHASE_TOP))
            begin
                phase_next = '0;
            end
            else
            begin
                phase_next = phase_reg + PHASE_W'(1);
            end
        end
    end

    // column state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            phase_reg  <= '0;
            remain_reg <= '0;
        end
        else
        begin
            column_reg <= column_next;
            phase_reg  <= phase_next;
            if (cmd.load_tab)
            begin
                remain_reg <= run - RUN_W'(1);
            end
            else if (cmd.load_space)
            begin
                remain_reg <= remain_reg - RUN_W'(1);
            end
        end
    end

    // output item register
    always_ff @(posedge clk)
    begin
        if (cmd.load_char)
        begin
            data_reg <= s_tdata;
            last_reg <= 1'b1;
        end
        else if (cmd.load_tab)
        begin
            data_reg <= SPACE_CODE;
            last_reg <= (run == RUN_W'(1));
        end
        else if (cmd.load_space)
        begin
            data_reg <= SPACE_CODE;
            last_reg <= (remain_reg == RUN_W'(1));
        end
    end

    assign m_tdata = data_reg;
    assign m_tlast = last_reg;

endmodule

// File: rtl/tab_expansion_filter_top.sv
// top level of the tab expansion filter
`timescale 1ns / 1ps

// Tab expansion filter: takes one character byte per input item and emits it
// unchanged, except that a tab is replaced by a run of spaces reaching the
// next tab stop (the first enabled user stop beyond the current column, else
// the next multiple of DEFAULT_INTERVAL, a run being at most 63 spaces).
// A newline resets the column to zero; the column otherwise wraps at 16 bits.
// m_tlast marks the final output item caused by each input item. Non-tab
// bytes stream at one per cycle while the output is not stalled. A tab
// produces 1 to 63 spaces: the single output register emits one space per
// cycle while not stalled, and input is held off until the last space of
// the run has been loaded. Stop registers are written through the cfg port,
// which is always ready, and should only be written while the block is idle.

module tab_expansion_filter_top
    import tef_pkg::*;
#(
    parameter int DEFAULT_INTERVAL = DEFAULT_INTERVAL_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // config write channel: index 0 stop_count, index 1 stop_table
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] char_in
    // output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [7:0] char_out
    output logic                   m_tlast    // last_of_run
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    // controller
    tef_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    tef_datapath #(
        .DEFAULT_INTERVAL (DEFAULT_INTERVAL)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

    // a run in progress keeps the output valid until its last space
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |=> m_tvalid)
        else $error("output run broken before last item");

    // only spaces can be non-last items
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata == SPACE_CODE)
        else $error("non-last output item is not a space");

    // no input is taken while spaces of a run are being loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_space |-> !(s_tvalid && s_tready))
        else $error("input accepted during a tab run");

    // a non-tab byte comes out next cycle as a single last item
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata != TAB_CODE) |=>
            m_tvalid && m_tlast && (m_tdata == $past(s_tdata)))
        else $error("pass-through byte not presented");

endmodule

// File: test/tb_top.sv
// self-checking testbench for the tab expansion filter top level
`timescale 1ns / 1ps

module tb_top;
    import tef_pkg::*;

    localparam int TAB_IVL   = DEFAULT_INTERVAL_DEF;
    localparam int WATCHDOG  = 2000;
    localparam int N_DIR     = 30;
    localparam int N_SEG     = 5;
    localparam int SEG_ITEMS = 16;

    // kinds of rows in the directed table
    typedef enum logic [1:0] {
        ROW_CHAR,
        ROW_CFG
    } row_kind_t;

    // one directed row: a character item or a register write
    typedef struct packed {
        row_kind_t             kind;
        cfg_reg_t              idx;
        logic [CFG_DATA_W-1:0] val;
        logic                  typed;
        logic [7:0]            exp_ch;
        logic [6:0]            exp_run;
    } stim_row_t;

    // fixed expectation attached to a sent character, if any
    typedef struct packed {
        logic       typed;
        logic [7:0] ch;
        logic [6:0] run;
    } fixed_exp_t;

    // one expected output item
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_item_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_reg_t              cfg_index = REG_STOP_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [7:0] char_in
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;          // [7:0] char_out
    logic                  m_tlast;          // last_of_run

    // predictor copy of the registers and the column
    logic [COUNT_W-1:0]    stop_cnt_q = '0;
    logic [CFG_DATA_W-1:0] stop_tbl_q = '0;
    logic [COLUMN_W-1:0]   col_q      = '0;

    out_item_t  out_exp_q [$];
    fixed_exp_t fixed_q [$];

    bit          quiet_mode = 1'b0;
    int unsigned errors     = 0;
    int unsigned n_in       = 0;
    int unsigned n_out      = 0;
    int unsigned n_tabs     = 0;
    int unsigned n_cfg      = 0;
    int unsigned max_run    = 0;
    int unsigned idle_cnt   = 0;

    stim_row_t dir_tab [0:N_DIR-1] = '{
        // after reset: default stops every 8 columns
        '{ROW_CHAR, REG_STOP_COUNT, 48'h41, 1'b1, 8'h41, 7'd1},
        '{ROW_CHAR, REG_STOP_COUNT, 48'(TAB_CODE), 1'b1, SPACE_CODE, 7'd7},
        '{ROW_CHAR, REG_STOP_COUNT, 48'(TAB_CODE), 1'b1, SPACE_CODE, 7'd8},
        '{ROW_CHAR, REG_STOP_COUNT, 48'h00, 1'b1, 8'h00, 7'd1},
        '{ROW_CHAR, REG_STOP_COUNT, 48'hFF, 1'b1, 8'hFF, 7'd1},
        '{ROW_CHAR, REG_STOP_COUNT, 48'(NEWLINE_CODE), 1'b1, NEWLINE_CODE, 7'd1},
        '{ROW_CHAR, REG_STOP_COUNT, 48'(TAB_CODE), 1'b1, SPACE_CODE, 7'd8},
        // unsorted stops 5, 3, 63; a tab exactly on a stop; fallback past them
        '{ROW_CFG, REG_STOP_TABLE, {30'd0, 6'd63, 6'd3, 6'd5}, 1'b0, 8'h00, 7'd0},
        '{ROW_CFG, REG_STOP_COUNT, 48'd3, 1'b0, 8'h00, 7'd0},
        '{ROW_CHAR, REG_STOP_COUNT, 48'(NEWLINE_CODE), 1'b0, 8'h00, 7'd0},
        '{ROW_CHAR, REG_STOP_COUNT, 48'(TAB_CODE), 1'b0, 8'h00, 7'd0},
        '{ROW_CHAR, REG_STOP_COUNT, 48'(TAB_CODE), 1'b0, 8'h00, 7'd0},
        '{ROW_CHAR, REG_STOP_COUNT, 48'(TAB_CODE), 1'b0, 8'h00, 7'd0},
        '{ROW_CHAR, REG_STOP_COUNT, 48'h78, 1'b0, 8'h00, 7'd0},
        // count above the table size, all stops at 63: longest run
        '{ROW_CFG, REG_STOP_TABLE, 48'hFFFF_FFFF_FFFF, 1'b0, 8'h00, 7'd0},
        '{ROW_CFG, REG_STOP_COUNT, 48'd15, 1'b0, 8'h00, 7'd0},
        '{ROW_CHAR, REG_STOP_COUNT, 48'(NEWLINE_CODE), 1'b0, 8'h00, 7'd0},
        '{ROW_CHAR, REG_STOP_COUNT, 48'(TAB_CODE), 1'b1, SPACE_CODE, 7'd63},
        '{ROW_CHAR, REG_STOP_COUNT, 48'(TAB_CODE), 1'b0, 8'h00, 7'd0},
        // only the last slot holds a usable stop
        '{ROW_CFG, REG_STOP_TABLE, {6'd40, 42'd0}, 1'b0, 8'h00, 7'd0},
        '{ROW_CFG, REG_STOP_COUNT, 48'd8, 1'b0, 8'h00, 7'd0},
        '{ROW_CHAR, REG_STOP_COUNT, 48'(NEWLINE_CODE), 1'b0, 8'h00, 7'd0},
        '{ROW_CHAR, REG_STOP_COUNT, 48'(TAB_CODE), 1'b0, 8'h00, 7'd0},
        '{ROW_CHAR, REG_STOP_COUNT, 48'h08, 1'b0, 8'h00, 7'd0},
        // zero count ignores a loaded table
        '{ROW_CFG, REG_STOP_COUNT, 48'd0, 1'b0, 8'h00, 7'd0},
        '{ROW_CHAR, REG_STOP_COUNT, 48'(NEWLINE_CODE), 1'b0, 8'h00, 7'd0},
        '{ROW_CHAR, REG_STOP_COUNT, 48'(TAB_CODE), 1'b0, 8'h00, 7'd0},
        '{ROW_CHAR, REG_STOP_COUNT, 48'h0B, 1'b0, 8'h00, 7'd0},
        '{ROW_CHAR, REG_STOP_COUNT, 48'h20, 1'b0, 8'h00, 7'd0},
        '{ROW_CHAR, REG_STOP_COUNT, 48'h80, 1'b0, 8'h00, 7'd0}
    };

    tab_expansion_filter_top #(
        .DEFAULT_INTERVAL (TAB_IVL)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #6 clk = ~clk;

    // number of spaces a tab at column col expands to
    function automatic int unsigned spaces_needed(logic [COLUMN_W-1:0] col);
        int unsigned n;
        int unsigned ivl;
        int unsigned run;
        logic [STOP_W-1:0] stop;
        n = stop_cnt_q;
        if (n > MAX_STOPS)
            n = MAX_STOPS;
        for (int k = 0; k < n; k++)
        begin
            stop = stop_tbl_q[STOP_W*k +: STOP_W];
            if (stop > col)
                return stop - col;
        end
        ivl = (TAB_IVL == 0) ? 1 : TAB_IVL;
        run = ivl - (col % ivl);
        if (run > RUN_LIMIT)
            run = RUN_LIMIT;
        return run;
    endfunction

    function automatic int unsigned draw_gap();
        return quiet_mode ? 0 : $urandom_range(0, 16);
    endfunction

    // send one character item, called and returning at a rising edge
    task automatic push_char(input logic [7:0] c, input fixed_exp_t fx);
        int unsigned gap;
        gap = draw_gap();
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        fixed_q.push_back(fx);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop sending and wait until every expected item has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (out_exp_q.size() != 0)
            @(negedge clk);
        @(posedge clk);
        repeat (2)
            @(posedge clk);
    endtask

    // register write while the block is idle
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_STOP_COUNT)
            stop_cnt_q = val[COUNT_W-1:0];
        else
            stop_tbl_q = val;
        n_cfg++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] rand_char();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            return TAB_CODE;
        else if (pick < 40)
            return NEWLINE_CODE;
        return 8'($urandom_range(0, 255));
    endfunction

    // output side: random stall before each item
    initial
    begin
        int unsigned gap;
        @(posedge clk);
        forever
        begin
            gap = draw_gap();
            repeat (gap)
            begin
                m_tready <= 1'b0;
                @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // predict on accepted input items, check accepted output items
    always @(posedge clk)
    begin : scoreboard
        fixed_exp_t  fx;
        out_item_t   e;
        logic [7:0]  ch;
        int unsigned run;
        if (rst_n)
        begin
            // expected items for an accepted character
            if (s_tvalid && s_tready)
            begin
                fx = (fixed_q.size() != 0) ? fixed_q.pop_front() : '0;
                if (s_tdata == TAB_CODE)
                begin
                    run = spaces_needed(col_q);
                    col_q = col_q + COLUMN_W'(run);
                    ch = SPACE_CODE;
                    n_tabs++;
                    if (run > max_run)
                        max_run = run;
                end
                else
                begin
                    run = 1;
                    ch = s_tdata;
                    col_q = (s_tdata == NEWLINE_CODE) ? '0 : col_q + 1'b1;
                end
                if (fx.typed)
                begin
                    run = fx.run;
                    ch = fx.ch;
                end
                for (int k = 0; k < run; k++)
                begin
                    e.ch = ch;
                    e.last = (k + 1 == run);
                    out_exp_q.push_back(e);
                end
                n_in++;
            end
            // compare an accepted output item with the oldest expectation
            if (m_tvalid && m_tready)
            begin
                n_out++;
                if (out_exp_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected item, expected none, got char %h last %b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    e = out_exp_q.pop_front();
                    if (m_tdata !== e.ch || m_tlast !== e.last)
                    begin
                        errors++;
                        $display("%0t: mismatch, expected char %h last %b, got char %h last %b",
                                 $time, e.ch, e.last, m_tdata, m_tlast);
                    end
                end
            end
            // watchdog on cycles with no handshake at all
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= WATCHDOG)
            begin
                $display("%0t: watchdog, no handshake for %0d cycles, %0d items outstanding",
                         $time, idle_cnt, out_exp_q.size());
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin
        fixed_exp_t fx;
        fixed_exp_t no_fx;
        no_fx = '0;

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < N_DIR; i++)
        begin
            if (dir_tab[i].kind == ROW_CFG)
            begin
                drain();
                write_reg(dir_tab[i].idx, dir_tab[i].val);
            end
            else
            begin
                fx.typed = dir_tab[i].typed;
                fx.ch    = dir_tab[i].exp_ch;
                fx.run   = dir_tab[i].exp_run;
                push_char(dir_tab[i].val[7:0], fx);
            end
        end

        // random segments, each under its own register setting
        for (int seg = 0; seg < N_SEG; seg++)
        begin
            drain();
            write_reg(REG_STOP_TABLE, CFG_DATA_W'({$urandom, $urandom}));
            write_reg(REG_STOP_COUNT,
                      CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(9, 15)
                                                              : $urandom_range(0, 8)));
            quiet_mode = (seg == 1);
            for (int j = 0; j < SEG_ITEMS; j++)
            begin
                // hold off once until everything in flight has come out
                if (seg == 2 && j == SEG_ITEMS / 2)
                    drain();
                push_char(rand_char(), no_fx);
            end
        end
        quiet_mode = 1'b0;

        drain();
        repeat (8)
            @(posedge clk);
        if (out_exp_q.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected items never came out", $time, out_exp_q.size());
        end

        $display("tb_top: %0d items in, %0d items out, %0d tabs, longest run %0d spaces",
                 n_in, n_out, n_tabs, max_run);
        $display("tb_top: %0d register writes over fixed and random stop tables, %0d mismatches",
                 n_cfg, errors);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
